>>> sv/key_repeat_and_battery_monitor_core_defines.svh
// Assertion macros used by the checker of the key repeat and battery monitor core.
`ifndef KEY_REPEAT_AND_BATTERY_MONITOR_CORE_DEFINES_SVH
`define KEY_REPEAT_AND_BATTERY_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KRBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KRBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/krbm_pkg.sv
// Types and constants of the key repeat and battery monitor core.
package krbm_pkg;

    localparam int KEYS_W    = 7;
    localparam int SAMPLE_W  = 12;
    localparam int CODE_W    = 3;
    localparam int LEVEL_W   = 3;
    localparam int COUNT_W   = 8;
    localparam int SUM_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [COUNT_W-1:0]  SCAN_DIVIDER_RESET    = 8'd20;
    localparam logic [COUNT_W-1:0]  BATTERY_EVERY_RESET   = 8'd5;
    localparam logic [SAMPLE_W-1:0] LEVEL3_RESET          = 12'd3000;
    localparam logic [SAMPLE_W-1:0] LEVEL2_RESET          = 12'd2730;
    localparam logic [SAMPLE_W-1:0] LEVEL1_RESET          = 12'd2460;
    localparam logic [COUNT_W-1:0]  HOLD_DELAY_RESET      = 8'd25;
    localparam logic [COUNT_W-1:0]  REPEAT_INTERVAL_RESET = 8'd3;
    localparam logic [COUNT_W-1:0]  BATTERY_COUNT_RESET   = 8'd5;
    localparam logic [SUM_W-1:0]    BATTERY_SUM_RESET     = SUM_W'(3200 * 32);

    localparam logic [CODE_W-1:0]  KEY_NONE  = 3'd0;
    localparam logic [CODE_W-1:0]  KEY_M     = 3'd1;
    localparam logic [CODE_W-1:0]  KEY_B     = 3'd2;
    localparam logic [CODE_W-1:0]  KEY_UP    = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_0   = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1   = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2   = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_3   = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_USB = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_DIVIDER,
        CFG_BATTERY_EVERY,
        CFG_LEVEL3_THRESHOLD,
        CFG_LEVEL2_THRESHOLD,
        CFG_LEVEL1_THRESHOLD,
        CFG_HOLD_DELAY,
        CFG_REPEAT_INTERVAL
    } krbm_cfg_idx_t;

    typedef struct packed {
        logic [KEYS_W-1:0]   keys_pressed;
        logic                usb_power;
        logic [SAMPLE_W-1:0] battery_sample;
    } krbm_in_t;

    typedef struct packed {
        logic               key_valid;
        logic [CODE_W-1:0]  key_code;
        logic [LEVEL_W-1:0] power_level;
        logic               power_changed;
    } krbm_out_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  scan_divider;
        logic [COUNT_W-1:0]  battery_every;
        logic [SAMPLE_W-1:0] level3_threshold;
        logic [SAMPLE_W-1:0] level2_threshold;
        logic [SAMPLE_W-1:0] level1_threshold;
        logic [COUNT_W-1:0]  hold_delay;
        logic [COUNT_W-1:0]  repeat_interval;
    } krbm_cfg_t;

endpackage

>>> sv/krbm_cfg_regs.sv
// Configuration register file of the key repeat and battery monitor core.
module krbm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [krbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [krbm_pkg::CFG_DATA_W-1:0] cfg_data,
    output krbm_pkg::krbm_cfg_t            cfg
);
    import krbm_pkg::*;

    krbm_cfg_t cfg_reg;
    krbm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_DIVIDER:     cfg_next.scan_divider     = cfg_data[COUNT_W-1:0];
                CFG_BATTERY_EVERY:    cfg_next.battery_every    = cfg_data[COUNT_W-1:0];
                CFG_LEVEL3_THRESHOLD: cfg_next.level3_threshold = cfg_data[SAMPLE_W-1:0];
                CFG_LEVEL2_THRESHOLD: cfg_next.level2_threshold = cfg_data[SAMPLE_W-1:0];
                CFG_LEVEL1_THRESHOLD: cfg_next.level1_threshold = cfg_data[SAMPLE_W-1:0];
                CFG_HOLD_DELAY:       cfg_next.hold_delay       = cfg_data[COUNT_W-1:0];
                CFG_REPEAT_INTERVAL:  cfg_next.repeat_interval  = cfg_data[COUNT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_divider     <= SCAN_DIVIDER_RESET;
            cfg_reg.battery_every    <= BATTERY_EVERY_RESET;
            cfg_reg.level3_threshold <= LEVEL3_RESET;
            cfg_reg.level2_threshold <= LEVEL2_RESET;
            cfg_reg.level1_threshold <= LEVEL1_RESET;
            cfg_reg.hold_delay       <= HOLD_DELAY_RESET;
            cfg_reg.repeat_interval  <= REPEAT_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/krbm_engine.sv
// Tick state and next-state logic: scan divider, battery average and key repeat.
module krbm_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  krbm_pkg::krbm_cfg_t cfg,
    input  krbm_pkg::krbm_in_t  tick,
    output krbm_pkg::krbm_out_t result
);
    import krbm_pkg::*;

    logic [COUNT_W-1:0] scan_count_reg, scan_count_next;
    logic [COUNT_W-1:0] battery_count_reg, battery_count_next;
    logic [SUM_W-1:0]   battery_sum_reg, battery_sum_next;
    logic [CODE_W-1:0]  last_key_reg, last_key_next;
    logic [COUNT_W-1:0] wait_count_reg, wait_count_next;
    logic               long_press_done_reg, long_press_done_next;
    logic [LEVEL_W-1:0] level_now_reg, level_now_next;

    logic [COUNT_W-1:0]  battery_inc;
    logic [SAMPLE_W-1:0] avg;
    logic [LEVEL_W-1:0]  level;
    logic [COUNT_W-1:0]  wait_dec;
    logic [CODE_W-1:0]   key;

    // Lowest set bit wins.
    always_comb
    begin
        key = KEY_NONE;
        for (int b = KEYS_W - 1; b >= 0; b--)
        begin
            if (tick.keys_pressed[b])
                key = CODE_W'(b + 1);
        end
    end

    assign battery_inc = battery_count_reg + 8'd1;
    assign avg         = battery_sum_reg[SUM_W-1:5];
    assign wait_dec    = (wait_count_reg != '0) ? wait_count_reg - 8'd1 : wait_count_reg;

    always_comb
    begin
        if (tick.usb_power)
            level = LEVEL_USB;
        else if (avg > cfg.level3_threshold)
            level = LEVEL_3;
        else if (avg > cfg.level2_threshold)
            level = LEVEL_2;
        else if (avg > cfg.level1_threshold)
            level = LEVEL_1;
        else
            level = LEVEL_0;
    end

    always_comb
    begin
        scan_count_next      = scan_count_reg;
        battery_count_next   = battery_count_reg;
        battery_sum_next     = battery_sum_reg;
        last_key_next        = last_key_reg;
        wait_count_next      = wait_count_reg;
        long_press_done_next = long_press_done_reg;
        level_now_next       = level_now_reg;
        result.key_valid     = 1'b0;
        result.key_code      = KEY_NONE;
        result.power_changed = 1'b0;

        if (scan_count_reg != '0)
        begin
            scan_count_next = scan_count_reg - 8'd1;
        end
        else
        begin
            scan_count_next    = cfg.scan_divider;
            battery_count_next = battery_inc;
            if (battery_inc >= cfg.battery_every)
            begin
                // Level comes from the average before this sample is folded in.
                battery_sum_next = battery_sum_reg + SUM_W'(tick.battery_sample)
                                   - SUM_W'(avg);
                if (level != level_now_reg)
                begin
                    level_now_next       = level;
                    result.power_changed = 1'b1;
                end
                battery_count_next = '0;
            end

            wait_count_next = wait_dec;
            if (key != KEY_NONE)
            begin
                if (key == last_key_reg)
                begin
                    if (wait_dec == '0)
                    begin
                        if (key >= KEY_UP)
                        begin
                            wait_count_next  = cfg.repeat_interval;
                            result.key_valid = 1'b1;
                            result.key_code  = key;
                        end
                        else if (key == KEY_M && !long_press_done_reg)
                        begin
                            long_press_done_next = 1'b1;
                            result.key_valid     = 1'b1;
                            result.key_code      = KEY_B;
                        end
                    end
                end
                else
                begin
                    wait_count_next      = cfg.hold_delay;
                    long_press_done_next = 1'b0;
                    result.key_valid     = 1'b1;
                    result.key_code      = key;
                end
            end
            last_key_next = key;
        end
        result.power_level = level_now_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_count_reg      <= '0;
            battery_count_reg   <= BATTERY_COUNT_RESET;
            battery_sum_reg     <= BATTERY_SUM_RESET;
            last_key_reg        <= KEY_NONE;
            wait_count_reg      <= '0;
            long_press_done_reg <= 1'b0;
            level_now_reg       <= LEVEL_0;
        end
        else if (step)
        begin
            scan_count_reg      <= scan_count_next;
            battery_count_reg   <= battery_count_next;
            battery_sum_reg     <= battery_sum_next;
            last_key_reg        <= last_key_next;
            wait_count_reg      <= wait_count_next;
            long_press_done_reg <= long_press_done_next;
            level_now_reg       <= level_now_next;
        end
    end

endmodule

>>> sv/key_repeat_and_battery_monitor_core.sv
// A tick accepted into the input register moves into the result register when that one is free or leaving.
// Throughput: one tick per cycle while out_stall is low; the engine's next-state logic is combinational.
// While a result waits under out_stall the input register still takes one tick; in_stall
// rises once both registers are full.
// Reset (rst_n low, asynchronous) empties both registers and restores the counters,
// the running battery sum (102400) and all configuration registers to their defaults.
module key_repeat_and_battery_monitor_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  krbm_pkg::krbm_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output krbm_pkg::krbm_out_t            out_data,
    input  logic                           cfg_we,
    input  logic [krbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [krbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import krbm_pkg::*;

    logic      in_valid_reg, in_valid_next;
    krbm_in_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    krbm_out_t out_data_reg;
    krbm_cfg_t cfg;
    krbm_out_t result;
    logic      advance;
    logic      take;

    krbm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    krbm_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cfg    (cfg),
        .tick   (in_data_reg),
        .result (result)
    );

    // Move the held tick into the result register when that one is free or leaving.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/krbm_checker.sv
// Port-level assertions for the key repeat and battery monitor core, with its bind.
`include "key_repeat_and_battery_monitor_core_defines.svh"

module krbm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input krbm_pkg::krbm_in_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input krbm_pkg::krbm_out_t out_data
);
    import krbm_pkg::*;

    logic key_code_set;
    logic level_ok;

    assign key_code_set = out_data.key_code != KEY_NONE;
    assign level_ok     = out_data.power_level == LEVEL_0 || out_data.power_level == LEVEL_1
                          || out_data.power_level == LEVEL_2 || out_data.power_level == LEVEL_3
                          || out_data.power_level == LEVEL_USB;

    `KRBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled result beat changed")
    `KRBM_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
        in_valid && $stable(in_data), "stalled input beat changed")
    `KRBM_ASSERT_NOW(a_key_code, out_valid, out_data.key_valid == key_code_set,
        "key_valid disagrees with key_code")
    `KRBM_ASSERT_NOW(a_level_range, out_valid, level_ok, "power level out of range")
    // Input only backs up when a result is waiting under stall.
    `KRBM_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall,
        "input stalled with the result register free")

endmodule

bind key_repeat_and_battery_monitor_core krbm_checker u_krbm_checker (.*);
